### rtl/ptrq_pkg.sv
// ----------------------------------------------------------------------------
// ptrq_pkg
// Shared types and codes for the per-type event ring queues.
// ----------------------------------------------------------------------------
package ptrq_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } ptrq_state_t;

    // Action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_BADTYPE = 2'd3;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input transfer
        logic exec;      // update queue state, issue memory access
        logic load_out;  // move the finished result into the output register
    } ptrq_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } ptrq_sts_t;

endpackage

### rtl/ptrq_ctrl.sv
// ----------------------------------------------------------------------------
// ptrq_ctrl
// Sequencer: accept, execute, finish; one item in flight.
// ----------------------------------------------------------------------------
module ptrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptrq_pkg::ptrq_sts_t sts,
    output ptrq_pkg::ptrq_cmd_t cmd
);

    ptrq_pkg::ptrq_state_t state_reg;
    ptrq_pkg::ptrq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptrq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptrq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ptrq_pkg::ST_EXEC;
                end
            end
            ptrq_pkg::ST_EXEC: begin
                state_next = ptrq_pkg::ST_FIN;
            end
            ptrq_pkg::ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ptrq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptrq_pkg::ST_IDLE;
            end
        endcase
    end

    // No transfer is taken while reset is held
    always_comb begin
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ptrq_pkg::ST_IDLE: begin
                s_ready     = aresetn;
                cmd.capture = s_valid && aresetn;
            end
            ptrq_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ptrq_pkg::ST_FIN: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/ptrq_datapath.sv
// ----------------------------------------------------------------------------
// ptrq_datapath
// Input latch, per-queue pointers and counters, event memory, output register.
// ----------------------------------------------------------------------------
module ptrq_datapath #(
    parameter int NUM_QUEUES   = 4,
    parameter int QUEUE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 32,
    localparam int IDX_W  = $clog2(QUEUE_DEPTH),
    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ptrq_pkg::ptrq_cmd_t     cmd,
    output ptrq_pkg::ptrq_sts_t     sts,
    input  logic                    s_action,
    input  logic [2:0]              s_device_type,
    input  logic [PAYLOAD_BITS-1:0] s_event_payload,
    input  logic [31:0]             s_event_time,
    input  logic [31:0]             s_now_ms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [PAYLOAD_BITS-1:0] m_out_payload,
    output logic [31:0]             m_out_time,
    output logic [31:0]             m_drop_total,
    output logic [CNT_W-1:0]        m_fill_level
);

    localparam int ADDR_W    = QSEL_W + IDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int MEM_W     = PAYLOAD_BITS + 32;

    // Latched request; timestamp already stamped
    logic                    act_reg;
    logic [2:0]              type_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [31:0]             time_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_action;
            type_reg <= s_device_type;
            pay_reg  <= s_event_payload;
            time_reg <= (s_event_time == '0) ? s_now_ms : s_event_time;
        end
    end

    // Per-queue state
    logic [IDX_W-1:0] rd_idx_reg [NUM_QUEUES];
    logic [IDX_W-1:0] wr_idx_reg [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_reg    [NUM_QUEUES];
    logic [31:0]      drop_reg   [NUM_QUEUES];

    logic              bad_type;
    logic [QSEL_W-1:0] qsel;
    logic [IDX_W-1:0]  cur_rd, cur_wr, rd_next, wr_next;
    logic [CNT_W-1:0]  cur_cnt, cnt_next;
    logic [31:0]       cur_drop, drop_next;
    logic              is_pop, full, empty, do_write, do_read, do_drop;
    logic [1:0]        status_next;
    logic [31:0]       time_next;

    assign bad_type = {1'b0, type_reg} >= 4'(NUM_QUEUES);
    assign qsel     = type_reg[QSEL_W-1:0];
    assign cur_rd   = rd_idx_reg[qsel];
    assign cur_wr   = wr_idx_reg[qsel];
    assign cur_cnt  = cnt_reg[qsel];
    assign cur_drop = drop_reg[qsel];

    assign is_pop   = (act_reg == ptrq_pkg::ACT_POP);
    assign full     = (cur_cnt == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cur_cnt == '0);
    assign do_write = !bad_type && !is_pop && !full;
    assign do_drop  = !bad_type && !is_pop && full;
    assign do_read  = !bad_type && is_pop && !empty;

    assign rd_next = (cur_rd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
    assign wr_next = (cur_wr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : cur_wr + 1'b1;

    always_comb begin
        cnt_next    = cur_cnt;
        drop_next   = cur_drop;
        status_next = ptrq_pkg::STATUS_DONE;
        time_next   = time_reg;
        if (bad_type) begin
            status_next = ptrq_pkg::STATUS_BADTYPE;
            time_next   = '0;
            cnt_next    = '0;
            drop_next   = '0;
        end else if (!is_pop) begin
            if (full) begin
                status_next = ptrq_pkg::STATUS_FULL;
                if (cur_drop != '1) begin
                    drop_next = cur_drop + 32'd1;
                end
            end else begin
                cnt_next = cur_cnt + 1'b1;
            end
        end else begin
            time_next = '0;
            if (empty) begin
                status_next = ptrq_pkg::STATUS_EMPTY;
            end else begin
                cnt_next = cur_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                rd_idx_reg[i] <= '0;
                wr_idx_reg[i] <= '0;
                cnt_reg[i]    <= '0;
                drop_reg[i]   <= '0;
            end
        end else if (cmd.exec) begin
            if (do_write) begin
                wr_idx_reg[qsel] <= wr_next;
                cnt_reg[qsel]    <= cnt_next;
            end
            if (do_read) begin
                rd_idx_reg[qsel] <= rd_next;
                cnt_reg[qsel]    <= cnt_next;
            end
            if (do_drop) begin
                drop_reg[qsel] <= drop_next;
            end
        end
    end

    // Event memory: {payload, time}, addressed by {queue, slot}
    logic [MEM_W-1:0] mem [MEM_DEPTH];
    logic [MEM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_write) begin
            mem[{qsel, cur_wr}] <= {pay_reg, time_reg};
        end
        if (cmd.exec) begin
            rdata_reg <= mem[{qsel, cur_rd}];
        end
    end

    // Result held until read data is back
    logic [1:0]       res_status_reg;
    logic [31:0]      res_time_reg;
    logic [31:0]      res_drop_reg;
    logic [CNT_W-1:0] res_fill_reg;
    logic             res_read_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= status_next;
            res_time_reg   <= time_next;
            res_drop_reg   <= drop_next;
            res_fill_reg   <= cnt_next;
            res_read_reg   <= do_read;
        end
    end

    // Output register
    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [PAYLOAD_BITS-1:0] m_payload_reg;
    logic [31:0]             m_time_reg;
    logic [31:0]             m_drop_reg;
    logic [CNT_W-1:0]        m_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg  <= res_status_reg;
            m_payload_reg <= res_read_reg ? rdata_reg[MEM_W-1:32] : '0;
            m_time_reg    <= res_read_reg ? rdata_reg[31:0] : res_time_reg;
            m_drop_reg    <= res_drop_reg;
            m_fill_reg    <= res_fill_reg;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_payload = m_payload_reg;
    assign m_out_time    = m_time_reg;
    assign m_drop_total  = m_drop_reg;
    assign m_fill_level  = m_fill_reg;

endmodule

### rtl/per_type_event_ring_queues.sv
// ----------------------------------------------------------------------------
// per_type_event_ring_queues
// One ring FIFO of timestamped events per device type, with drop counting.
// ----------------------------------------------------------------------------
//
//  channel | direction | fields
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | action, device_type, event_payload, event_time, now_ms
//  m_      | out       | status, out_payload, out_time, drop_total, fill_level
//
//  An item passes through accept, execute (pointer update plus one access to
//  the event memory), finish (registered read data lands in the output reg).
//  The one-item sequencer takes no new transfer until the last has finished.
//  Finish waits while the output register still holds an untaken result;
//  a new transfer is taken in the meantime only once that result has moved.
//  Reset (aresetn, synchronous) clears pointers, counts and drop counters;
//  the event memory is not cleared, slots are only read after being written.
//
module per_type_event_ring_queues #(
    parameter int NUM_QUEUES   = 4,
    parameter int QUEUE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [2:0]                           s_device_type,
    input  logic [PAYLOAD_BITS-1:0]              s_event_payload,
    input  logic [31:0]                          s_event_time,
    input  logic [31:0]                          s_now_ms,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [PAYLOAD_BITS-1:0]              m_out_payload,
    output logic [31:0]                          m_out_time,
    output logic [31:0]                          m_drop_total,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   m_fill_level
);

    ptrq_pkg::ptrq_cmd_t cmd;
    ptrq_pkg::ptrq_sts_t sts;

    // Sequencer: one transfer at a time through accept/execute/finish
    ptrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Queue state, event memory and output register
    ptrq_datapath #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_action        (s_action),
        .s_device_type   (s_device_type),
        .s_event_payload (s_event_payload),
        .s_event_time    (s_event_time),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_payload   (m_out_payload),
        .m_out_time      (m_out_time),
        .m_drop_total    (m_drop_total),
        .m_fill_level    (m_fill_level)
    );

endmodule

### rtl/ptrq_checker.sv
// ----------------------------------------------------------------------------
// ptrq_checker
// Port-level checks for per_type_event_ring_queues, attached by bind.
// ----------------------------------------------------------------------------
module ptrq_checker #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic [PAYLOAD_BITS-1:0]            m_out_payload,
    input logic [31:0]                        m_out_time,
    input logic [31:0]                        m_drop_total,
    input logic [$clog2(QUEUE_DEPTH + 1)-1:0] m_fill_level
);

    // Result held stable until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_time))
        else $error("result changed before transfer");

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // Rejected type returns all-zero fields
    a_badtype_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ptrq_pkg::STATUS_BADTYPE |->
            m_out_payload == '0 && m_out_time == '0 && m_drop_total == '0
            && m_fill_level == '0)
        else $error("bad type result not zero");

    // Empty pop reports an empty queue and no data; drop implies full queue
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ptrq_pkg::STATUS_EMPTY
                    || m_status == ptrq_pkg::STATUS_FULL) |->
            (m_status == ptrq_pkg::STATUS_EMPTY && m_fill_level == '0
             && m_out_payload == '0 && m_out_time == '0)
            || (m_status == ptrq_pkg::STATUS_FULL && m_drop_total != '0
             && m_fill_level == ($clog2(QUEUE_DEPTH + 1))'(QUEUE_DEPTH)))
        else $error("empty or full result inconsistent");

endmodule

bind per_type_event_ring_queues ptrq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_ptrq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_out_payload (m_out_payload),
    .m_out_time    (m_out_time),
    .m_drop_total  (m_drop_total),
    .m_fill_level  (m_fill_level)
);
